@@ rtl/twtp_pkg.sv @@
// shared types and constants of the tilted window tail pruning block
package twtp_pkg;

  localparam int IDX_W = 7;
  localparam int COUNT_W = 32;
  localparam int FRAC_W = 16;
  localparam int SUM_W = 40;
  localparam int BOUND_W = IDX_W + 1;
  localparam int GRAN_W = 3;

  localparam int BUCKET_COUNT = 72;
  localparam int GRANULARITY_COUNT = 5;
  localparam int GROUP_REGS = 5;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_SUPPORT = 3'd0,
    REG_MAX_ERROR   = 3'd1,
    REG_GROUP_0     = 3'd2,
    REG_GROUP_1     = 3'd3,
    REG_GROUP_2     = 3'd4,
    REG_GROUP_3     = 3'd5,
    REG_GROUP_4     = 3'd6
  } reg_index_t;

  localparam logic [IDX_W-1:0] GROUP_START_RESET [GROUP_REGS] = '{
    7'd0, 7'd4, 7'd28, 7'd59, 7'd71
  };

  typedef struct packed {
    logic [FRAC_W-1:0]                 min_support;
    logic [FRAC_W-1:0]                 max_error;
    logic [GROUP_REGS-1:0][IDX_W-1:0]  group_start;
  } cfg_t;

  // classified bucket handed from the front to the back
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] support;
    logic [COUNT_W-1:0] events;
    logic               acc;
    logic               last;
  } q_item_t;

endpackage

@@ rtl/twtp_if.sv @@
// request channels of the tilted window tail pruning block
interface twtp_in_if;
  import twtp_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   bucket_index;
  logic [COUNT_W-1:0] pattern_support;
  logic [COUNT_W-1:0] batch_events;
  logic               bucket_unused;
  logic               final_bucket;

  modport source (output valid, bucket_index, pattern_support, batch_events,
                  bucket_unused, final_bucket, input ready);
  modport sink (input valid, bucket_index, pattern_support, batch_events,
                bucket_unused, final_bucket, output ready);
endinterface

interface twtp_out_if;
  import twtp_pkg::*;
  logic              valid;
  logic              ready;
  logic              tail_droppable;
  logic [GRAN_W-1:0] drop_granularity;

  modport source (output valid, tail_droppable, drop_granularity, input ready);
  modport sink (input valid, tail_droppable, drop_granularity, output ready);
endinterface

@@ rtl/twtp_cfg.sv @@
// configuration register file
module twtp_cfg
  import twtp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t                   regs;
  logic [CFG_INDEX_W-1:0] group_sel;

  assign group_sel = CFG_INDEX_W'(cfg_index - REG_GROUP_0);
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_support <= '0;
      regs.max_error <= '0;
      for (int i = 0; i < GROUP_REGS; i++) begin
        regs.group_start[i] <= GROUP_START_RESET[i];
      end
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_MIN_SUPPORT: regs.min_support <= cfg_wdata;
        REG_MAX_ERROR:   regs.max_error <= cfg_wdata;
        [REG_GROUP_0:REG_GROUP_4]: begin
          regs.group_start[group_sel] <= cfg_wdata[IDX_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/twtp_front.sv @@
// front end: accepts buckets and tracks the run below minimum support
module twtp_front
  import twtp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  twtp_in_if.sink bucket,
  input  cfg_t    cfg,
  input  logic    q_full,
  output logic    q_push,
  output q_item_t q_item
);

  logic                          below_min_run;
  logic                          accept;
  logic                          used;
  logic                          below_min;
  logic [COUNT_W+FRAC_W-1:0]     min_limit;

  assign bucket.ready = !q_full;
  assign accept = bucket.valid && bucket.ready;
  assign q_push = accept;

  // support < ceil(f * batch) done exactly as support * 2^16 < f * batch
  assign min_limit = (COUNT_W+FRAC_W)'(cfg.min_support) *
                     (COUNT_W+FRAC_W)'(bucket.batch_events);
  assign below_min = {bucket.pattern_support, {FRAC_W{1'b0}}} < min_limit;
  assign used = !bucket.bucket_unused;

  always_comb begin
    q_item.idx = bucket.bucket_index;
    q_item.support = bucket.pattern_support;
    q_item.events = bucket.batch_events;
    q_item.acc = used && below_min_run && below_min;
    q_item.last = bucket.final_bucket;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      below_min_run <= 1'b1;
    end else if (accept) begin
      if (bucket.final_bucket) begin
        below_min_run <= 1'b1;
      end else if (used && !below_min) begin
        below_min_run <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/twtp_queue.sv @@
// small queue of classified buckets between front and back
module twtp_queue
  import twtp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    pop_valid,
  output q_item_t pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t          slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = count == CNT_W'(DEPTH);
  assign pop_valid = count != '0;
  assign do_push = push && !full;
  assign do_pop = pop && pop_valid;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/twtp_back.sv @@
// back end: error scan pipeline, granularity pick and verdict register
module twtp_back
  import twtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  q_item_t     q_item,
  output logic        q_pop,
  twtp_out_if.source  verdict
);

  localparam int PROD_W = SUM_W + FRAC_W;

  logic en;

  // running sums of the current window
  logic [SUM_W-1:0] sum_support;
  logic [SUM_W-1:0] sum_events;
  logic [SUM_W:0]   add_support;
  logic [SUM_W:0]   add_events;
  logic [SUM_W-1:0] sat_support;
  logic [SUM_W-1:0] sat_events;
  logic [SUM_W-1:0] new_support;
  logic [SUM_W-1:0] new_events;

  // stage 1: sums after this bucket
  logic             v1;
  logic             acc1;
  logic             last1;
  logic [IDX_W-1:0] idx1;
  logic [SUM_W-1:0] s1_support;
  logic [SUM_W-1:0] s1_events;

  // stage 2: error limit product
  logic              v2;
  logic              acc2;
  logic              last2;
  logic [IDX_W-1:0]  idx2;
  logic [SUM_W-1:0]  s2_support;
  logic [PROD_W-1:0] s2_limit;

  // stage 3: scan two state
  logic             below_error_run;
  logic             prune_found;
  logic [IDX_W-1:0] prune_index;
  logic             hit;
  logic             below_error;
  logic             error_run_next;
  logic             found_next;
  logic [IDX_W-1:0] index_next;

  // window result waiting for the granularity pick
  logic             r_valid;
  logic             r_found;
  logic [IDX_W-1:0] r_index;

  logic               out_valid;
  logic [BOUND_W-1:0] bound [GRANULARITY_COUNT+1];
  logic [BOUND_W-1:0] r_index_wide;
  logic               drop_pick;
  logic [GRAN_W-1:0]  gran_pick;

  assign en = !out_valid || verdict.ready;
  assign q_pop = en;
  assign verdict.valid = out_valid;

  // saturating accumulate
  assign add_support = {1'b0, sum_support} + (SUM_W+1)'(q_item.support);
  assign add_events = {1'b0, sum_events} + (SUM_W+1)'(q_item.events);
  assign sat_support = add_support[SUM_W] ? '1 : add_support[SUM_W-1:0];
  assign sat_events = add_events[SUM_W] ? '1 : add_events[SUM_W-1:0];
  assign new_support = q_item.acc ? sat_support : sum_support;
  assign new_events = q_item.acc ? sat_events : sum_events;

  assign hit = v2 && acc2 && below_error_run;
  assign below_error = {s2_support, {FRAC_W{1'b0}}} < s2_limit;
  assign error_run_next = (hit && !below_error) ? 1'b0 : below_error_run;
  assign found_next = prune_found || (hit && below_error);
  assign index_next = (hit && below_error) ? idx2 : prune_index;

  assign r_index_wide = {1'b0, r_index};

  always_comb begin
    for (int g = 0; g < GRANULARITY_COUNT; g++) begin
      bound[g] = {1'b0, cfg.group_start[g]};
    end
    bound[GRANULARITY_COUNT] = BOUND_W'(BUCKET_COUNT);
    drop_pick = 1'b0;
    gran_pick = '0;
    for (int g = 0; g < GRANULARITY_COUNT; g++) begin
      if (!drop_pick && r_found && r_index_wide <= bound[g] &&
          r_index_wide < bound[g+1]) begin
        drop_pick = 1'b1;
        gran_pick = GRAN_W'(g);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      r_valid <= 1'b0;
      out_valid <= 1'b0;
      sum_support <= '0;
      sum_events <= '0;
      below_error_run <= 1'b1;
      prune_found <= 1'b0;
      prune_index <= '0;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      r_valid <= v2 && last2;
      out_valid <= r_valid;
      if (q_valid) begin
        sum_support <= q_item.last ? '0 : new_support;
        sum_events <= q_item.last ? '0 : new_events;
      end
      if (v2) begin
        if (last2) begin
          below_error_run <= 1'b1;
          prune_found <= 1'b0;
          prune_index <= '0;
        end else begin
          below_error_run <= error_run_next;
          prune_found <= found_next;
          prune_index <= index_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc1 <= q_item.acc;
      last1 <= q_item.last;
      idx1 <= q_item.idx;
      s1_support <= new_support;
      s1_events <= new_events;

      acc2 <= acc1;
      last2 <= last1;
      idx2 <= idx1;
      s2_support <= s1_support;
      s2_limit <= PROD_W'(cfg.max_error) * PROD_W'(s1_events);

      r_found <= found_next;
      r_index <= index_next;

      verdict.tail_droppable <= drop_pick;
      verdict.drop_granularity <= gran_pick;
    end
  end

endmodule

@@ rtl/tilted_window_tail_prune_top.sv @@
// top level of the tilted window tail pruning block
//
// decides how much of a pattern's tilted time window can be pruned. buckets
// enter on the bucket channel oldest first, one request per window position,
// the last one flagged final_bucket; an empty window is one unused final
// request. every final request yields exactly one verdict request carrying
// tail_droppable and drop_granularity; other buckets yield nothing. the block
// takes one bucket per clock cycle while the queue is not full, without a gap
// between windows. the front tests each bucket against min_support with a 16x32
// multiply and compare and tracks the run of low-support buckets; a queue of
// QUEUE_DEPTH entries decouples it from the back, which accumulates saturating
// 40-bit sums, forms max_support_error times the summed batch size in a 16x40
// multiply stage, updates the pruning scan and picks the granularity. a final
// bucket passes the queue, stage 1, stage 2, the window result register and the
// verdict register. configuration registers are written through cfg_we,
// cfg_index and cfg_wdata and must only change while no window is in flight.
module tilted_window_tail_prune_top
  import twtp_pkg::*;
#(
  parameter int QUEUE_DEPTH = twtp_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  twtp_in_if.sink                bucket,
  twtp_out_if.source             verdict,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // register file contents
  cfg_t    cfg;

  // front to queue
  logic    q_push;
  q_item_t q_push_item;
  logic    q_full;

  // queue to back
  logic    q_pop;
  logic    q_valid;
  q_item_t q_pop_item;

  twtp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // classify each bucket as it is taken
  twtp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .bucket (bucket),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_push_item)
  );

  // lets the front keep taking buckets while a verdict waits
  twtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_pop_item)
  );

  // error scan, granularity pick and verdict output register
  twtp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_pop_item),
    .q_pop   (q_pop),
    .verdict (verdict)
  );

  // a full queue must hold off the bucket channel
  assert property (@(posedge clk) disable iff (rst) q_full |-> !bucket.ready)
    else $error("bucket taken while queue full");

  // a verdict that drops nothing carries granularity zero
  assert property (@(posedge clk) disable iff (rst)
    verdict.valid && !verdict.tail_droppable |-> verdict.drop_granularity == '0)
    else $error("granularity set on a verdict that drops nothing");

  // the chosen granularity exists
  assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> verdict.drop_granularity < GRAN_W'(GRANULARITY_COUNT))
    else $error("granularity out of range");

endmodule
